### design/pdrc_pkg.sv
// Shared types and constants for the PLL divider register calculator.
package pdrc_pkg;

    localparam logic [25:0] XTAL_RESET     = 26'd25000000;
    localparam logic [29:0] VCO_CEIL_RESET = 30'd900000000;
    localparam logic [20:0] FRAC_DEN       = 21'd1048575;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_CHANNEL = 2'd1;
    localparam logic [1:0] ERR_RANGE   = 2'd2;

    localparam logic [1:0] CFG_XTAL     = 2'd0;
    localparam logic [1:0] CFG_VCO_CEIL = 2'd1;

    localparam logic [7:0] ADDR_PLLA     = 8'd26;
    localparam logic [7:0] ADDR_PLLB     = 8'd34;
    localparam logic [7:0] ADDR_MS0      = 8'd42;
    localparam logic [7:0] ADDR_MS1      = 8'd50;
    localparam logic [7:0] ADDR_PLLRST   = 8'd177;
    localparam logic [7:0] ADDR_CLK0     = 8'd16;
    localparam logic [7:0] ADDR_CLK1     = 8'd17;
    localparam logic [7:0] DATA_RST_A    = 8'h20;
    localparam logic [7:0] DATA_RST_B    = 8'h80;
    localparam logic [7:0] DATA_CLK0     = 8'h4F;
    localparam logic [7:0] DATA_CLK1     = 8'h6F;
    localparam logic [4:0] LAST_IDX      = 5'd17;

    // One classified request handed from the front end to the writer.
    typedef struct packed {
        logic [1:0]  err;
        logic        chl;
        logic [6:0]  ms;
        logic [7:0]  a;
        logic [20:0] b;
        logic [29:0] vco;
    } t_job;

    typedef struct packed {
        logic        start;
        logic [4:0]  steps;
        logic [34:0] num;
        logic [34:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [28:0] quo;
    } t_div_rsp;

endpackage

### design/pdrc_div.sv
// Bit-serial restoring divider producing a fraction of num/den (num < den).
module pdrc_div
    import pdrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [34:0] r_rem, r_den;
    logic [28:0] r_quo;
    logic [35:0] n_shift;
    logic        n_ge;

    always_comb begin
        n_shift = {r_rem, 1'b0};
        n_ge    = n_shift >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_cnt <= i_req.steps;
            r_quo <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            r_quo <= {r_quo[27:0], n_ge};
            r_rem <= n_ge ? 35'(n_shift - {1'b0, r_den}) : n_shift[34:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### design/pdrc_front.sv
// Front end: accepts requests, picks the divider and works out the PLL ratio.
module pdrc_front
    import pdrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_channel,
    input  logic [27:0] i_target_freq,
    input  logic [25:0] i_xtal,
    input  logic [29:0] i_vco_ceil,
    output logic        o_push,
    output t_job        o_job,
    input  logic        i_full
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_MSDIV = 3'd2;
    localparam logic [2:0] S_VT    = 3'd3;
    localparam logic [2:0] S_RCHK  = 3'd4;
    localparam logic [2:0] S_RDIV  = 3'd5;
    localparam logic [2:0] S_VCO   = 3'd6;
    localparam logic [2:0] S_PUSH  = 3'd7;

    logic [2:0]  r_state, n_state;
    logic        r_chl;
    logic [27:0] r_freq;
    logic [1:0]  r_err;
    logic [6:0]  r_ms;
    logic [34:0] r_vt;
    logic [7:0]  r_a;
    logic [20:0] r_b;
    logic [54:0] r_prod;
    t_div_req    n_div;
    t_div_rsp    div_rsp;
    logic [34:0] n_xd;
    logic [20:0] n_q;
    logic [28:0] n_mult;
    logic [54:0] n_round;

    pdrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div),
        .o_rsp   (div_rsp)
    );

    assign n_xd    = {1'b0, i_xtal, 8'd0};
    // b*2^20/(2^20-1) is b plus one once b reaches the denominator.
    assign n_q     = r_b + {20'd0, r_b >= FRAC_DEN};
    assign n_mult  = {1'b0, r_a, 20'd0} + {8'd0, n_q};
    assign n_round = r_prod + 55'd524288;

    always_comb begin
        n_state   = r_state;
        n_div     = '0;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_CHK;
            S_CHK: begin
                if (r_freq == 28'd0 || i_xtal == 26'd0 ||
                    {5'd0, i_vco_ceil} >= {r_freq, 7'd0}) begin
                    n_state = S_PUSH;
                end else begin
                    n_div.start = 1'b1;
                    n_div.steps = 5'd7;
                    n_div.num   = {5'd0, i_vco_ceil};
                    n_div.den   = {r_freq, 7'd0};
                    n_state     = S_MSDIV;
                end
            end
            S_MSDIV: if (div_rsp.done) n_state = (div_rsp.quo[6:2] == 5'd0) ? S_PUSH : S_VT;
            S_VT:    n_state = S_RCHK;
            S_RCHK: begin
                if (r_vt >= n_xd) begin
                    n_state = S_PUSH;
                end else begin
                    n_div.start = 1'b1;
                    n_div.steps = 5'd29;
                    n_div.num   = r_vt;
                    n_div.den   = n_xd;
                    n_state     = S_RDIV;
                end
            end
            S_RDIV:  if (div_rsp.done) n_state = S_VCO;
            S_VCO:   n_state = S_PUSH;
            S_PUSH:  if (!i_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_chl  <= i_channel;
                r_freq <= i_target_freq;
                r_err  <= ERR_OK;
            end
            S_CHK: begin
                if (n_state == S_PUSH) r_err <= ERR_RANGE;
            end
            S_MSDIV: begin
                r_ms <= {div_rsp.quo[6:1], 1'b0};
                if (div_rsp.done && div_rsp.quo[6:2] == 5'd0) r_err <= ERR_RANGE;
            end
            S_VT:   r_vt <= 35'(r_freq * r_ms);
            S_RCHK: begin
                if (n_state == S_PUSH) r_err <= ERR_RANGE;
            end
            S_RDIV: begin
                r_a <= div_rsp.quo[28:21];
                r_b <= 21'(({1'b0, div_rsp.quo[20:0]} + 22'd1) >> 1);
            end
            S_VCO:  r_prod <= 55'(i_xtal * n_mult);
            default: ;
        endcase
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_push    = (r_state == S_PUSH) && !i_full;
    assign o_job.err = r_err;
    assign o_job.chl = r_chl;
    assign o_job.ms  = r_ms;
    assign o_job.a   = r_a;
    assign o_job.b   = r_b;
    assign o_job.vco = n_round[49:20];

endmodule

### design/pdrc_fifo.sv
// Small queue of classified requests between the front end and the writer.
module pdrc_fifo
    import pdrc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= bump(r_wp);
            if (i_pop)  r_rp <= bump(r_rp);
            if (i_push && !i_pop)      r_cnt <= CW'(r_cnt + 1'b1);
            else if (i_pop && !i_push) r_cnt <= CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

endmodule

### design/pdrc_back.sv
// Writer: packs the register images and emits one write per cycle while the output is ready.
module pdrc_back
    import pdrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_reg_address,
    output logic [7:0]  o_reg_data,
    output logic [29:0] o_vco_freq,
    output logic [1:0]  o_error_code,
    output logic        o_last_write
);

    logic        r_valid, r_last;
    logic [4:0]  r_idx;
    logic [7:0]  r_addr, r_data;
    logic [29:0] r_vco;
    logic [1:0]  r_err;
    logic        n_load, n_done;
    logic [7:0]  n_addr, n_data, n_f, n_base;
    logic [17:0] n_p1, n_mp1;
    logic [19:0] n_p2;
    logic [20:0] n_q;
    logic        n_ms4;

    always_comb begin
        n_q   = i_job.b + {20'd0, i_job.b >= FRAC_DEN};
        n_f   = n_q[20:13];
        n_p1  = 18'({i_job.a, 7'd0} + {10'd0, n_f} - 18'd512);
        n_p2  = 20'({i_job.b, 7'd0} + {20'd0, n_f});
        n_mp1 = 18'({i_job.ms, 7'd0} - 18'd512);
        n_ms4 = (i_job.ms == 7'd4);
        n_data = 8'd0;
        if (r_idx < 5'd8) begin
            n_base = i_job.chl ? ADDR_PLLB : ADDR_PLLA;
            n_addr = n_base + {5'd0, r_idx[2:0]};
            case (r_idx[2:0])
                3'd0, 3'd1: n_data = 8'hFF;
                3'd2:       n_data = {6'd0, n_p1[17:16]};
                3'd3:       n_data = n_p1[15:8];
                3'd4:       n_data = n_p1[7:0];
                3'd5:       n_data = {4'hF, n_p2[19:16]};
                3'd6:       n_data = n_p2[15:8];
                default:    n_data = n_p2[7:0];
            endcase
        end else if (r_idx < 5'd16) begin
            n_base = i_job.chl ? ADDR_MS1 : ADDR_MS0;
            n_addr = n_base + {5'd0, r_idx[2:0]};
            case (r_idx[2:0])
                3'd1:    n_data = 8'd1;
                3'd2:    n_data = {4'd0, n_ms4, n_ms4, n_mp1[17:16]};
                3'd3:    n_data = n_mp1[15:8];
                3'd4:    n_data = n_mp1[7:0];
                default: n_data = 8'd0;
            endcase
        end else if (r_idx == 5'd16) begin
            n_base = ADDR_PLLRST;
            n_addr = ADDR_PLLRST;
            n_data = i_job.chl ? DATA_RST_B : DATA_RST_A;
        end else begin
            n_base = i_job.chl ? ADDR_CLK1 : ADDR_CLK0;
            n_addr = n_base;
            n_data = i_job.chl ? DATA_CLK1 : DATA_CLK0;
        end
        n_load = !i_empty && (!r_valid || i_ready);
        n_done = (i_job.err != ERR_OK) || (r_idx == LAST_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (n_load) begin
                r_valid <= 1'b1;
                r_idx   <= n_done ? 5'd0 : r_idx + 5'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_err  <= i_job.err;
            r_last <= n_done;
            if (i_job.err != ERR_OK) begin
                r_addr <= 8'd0;
                r_data <= 8'd0;
                r_vco  <= 30'd0;
            end else begin
                r_addr <= n_addr;
                r_data <= n_data;
                r_vco  <= i_job.vco;
            end
        end
    end

    assign o_pop         = n_load && n_done;
    assign o_valid       = r_valid;
    assign o_reg_address = r_addr;
    assign o_reg_data    = r_data;
    assign o_vco_freq    = r_vco;
    assign o_error_code  = r_err;
    assign o_last_write  = r_last;

endmodule

### design/pll_divider_register_calc.sv
// Top level of the PLL divider register calculator.
// Each request (channel, target frequency) yields eighteen register writes, one
// per cycle while the output is taken, or one error result. The front end works
// out each request with its bit-serial divider (7 quotient bits for the output
// divider and 29 for the feedback ratio) and its control states; a request that
// fails a range check is queued early as an error result. A request queue lets
// the front end work on the next request while the writer is still emitting the
// previous one. Configuration writes are always accepted, as their ready is tied
// high; only indexes 0 (crystal frequency) and 1 (VCO ceiling) have effect.
module pll_divider_register_calc
    import pdrc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_channel,
    input  logic [27:0] i_target_freq,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_reg_address,
    output logic [7:0]  o_reg_data,
    output logic [29:0] o_vco_freq,
    output logic [1:0]  o_error_code,
    output logic        o_last_write,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [29:0] i_cfg_data
);

    logic [25:0] r_xtal;
    logic [29:0] r_vco_ceil;
    logic        push, full, pop, empty;
    t_job        job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xtal     <= XTAL_RESET;
            r_vco_ceil <= VCO_CEIL_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_XTAL)     r_xtal     <= i_cfg_data[25:0];
            if (i_cfg_index == CFG_VCO_CEIL) r_vco_ceil <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    pdrc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_channel     (i_channel),
        .i_target_freq (i_target_freq),
        .i_xtal        (r_xtal),
        .i_vco_ceil    (r_vco_ceil),
        .o_push        (push),
        .o_job         (job_in),
        .i_full        (full)
    );

    pdrc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    pdrc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_job         (job_out),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_reg_address (o_reg_address),
        .o_reg_data    (o_reg_data),
        .o_vco_freq    (o_vco_freq),
        .o_error_code  (o_error_code),
        .o_last_write  (o_last_write)
    );

endmodule

### design/pdrc_checker.sv
// Port-level checks for the PLL divider register calculator, bound to the top.
module pdrc_checker
    import pdrc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_reg_address,
    input logic [7:0]  o_reg_data,
    input logic [29:0] o_vco_freq,
    input logic [1:0]  o_error_code,
    input logic        o_last_write
);

    logic        r_mid;
    logic [29:0] r_vco;

    // Tracks whether a request's writes have started but not yet finished.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_mid <= !o_last_write;
            r_vco <= o_vco_freq;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_OK |->
            o_last_write && o_reg_address == 8'd0 && o_reg_data == 8'd0 &&
            o_vco_freq == 30'd0)
        else $error("malformed error result");

    a_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_mid |-> o_error_code == ERR_OK)
        else $error("error inside a write sequence");

    a_mid_vco: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_mid |-> o_vco_freq == r_vco)
        else $error("vco frequency changed within a request");

endmodule

bind pll_divider_register_calc pdrc_checker u_pdrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_reg_address (o_reg_address),
    .o_reg_data    (o_reg_data),
    .o_vco_freq    (o_vco_freq),
    .o_error_code  (o_error_code),
    .o_last_write  (o_last_write)
);

### sim/testbench.sv
// Self-checking testbench for the PLL divider register calculator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pdrc_pkg::*;

    typedef struct {
        logic [7:0]  addr;
        logic [7:0]  data;
        logic [29:0] vco;
        logic [1:0]  err;
        logic        last;
    } t_write;

    class write_scoreboard;
        logic [25:0] xtal;
        logic [29:0] vco_ceil;
        t_write      pending[$];
        int          mismatches;

        function new();
            xtal = XTAL_RESET;
            vco_ceil = VCO_CEIL_RESET;
            mismatches = 0;
        endfunction

        function void add(logic [7:0] addr, logic [7:0] data, logic [29:0] vco,
                          logic [1:0] err, logic last);
            t_write w;
            w.addr = addr;
            w.data = data;
            w.vco = vco;
            w.err = err;
            w.last = last;
            pending.push_back(w);
        endfunction

        // Packs one ratio a + b/c into the eight parameter bytes.
        function void pack_ratio(logic [7:0] base, bit [63:0] a, bit [63:0] b,
                                 bit [63:0] c, logic [29:0] vco, bit div4);
            bit [63:0] p1, p2, f;
            logic [7:0] bytes [8];
            if (b == 0) begin
                p1 = (a << 7) - 512;
                p2 = 0;
            end else begin
                f = ((b << 20) / FRAC_DEN) >> 13;
                p1 = (a << 7) + f - 512;
                p2 = (b << 7) - 64'(FRAC_DEN) * f;
            end
            bytes[0] = c[15:8];
            bytes[1] = c[7:0];
            bytes[2] = {6'd0, p1[17:16]} | (div4 ? 8'h0C : 8'h00);
            bytes[3] = p1[15:8];
            bytes[4] = p1[7:0];
            bytes[5] = {c[19:16], p2[19:16]};
            bytes[6] = p2[15:8];
            bytes[7] = p2[7:0];
            for (int i = 0; i < 8; i++)
                add(base + 8'(i), bytes[i], vco, ERR_OK, 1'b0);
        endfunction

        function void note_request(logic chl, logic [27:0] freq);
            bit [63:0] ms, ratio, a, b, vco;
            if (freq == 0) begin
                add(8'd0, 8'd0, 30'd0, ERR_RANGE, 1'b1);
                return;
            end
            ms = (64'(vco_ceil) / freq) & ~64'd1;
            if (ms < 4 || ms > 126 || xtal == 0) begin
                add(8'd0, 8'd0, 30'd0, ERR_RANGE, 1'b1);
                return;
            end
            ratio = ((64'(freq) * ms) << 21) / xtal;
            a = ratio >> 21;
            if (a > 255) begin
                add(8'd0, 8'd0, 30'd0, ERR_RANGE, 1'b1);
                return;
            end
            b = ((ratio & 64'h1FFFFF) + 1) >> 1;
            vco = (64'(xtal) * (((b << 20) / FRAC_DEN) + (a << 20)) + (64'd1 << 19)) >> 20;
            pack_ratio(chl ? ADDR_PLLB : ADDR_PLLA, a, b, FRAC_DEN, vco[29:0], 1'b0);
            pack_ratio(chl ? ADDR_MS1 : ADDR_MS0, ms, 0, 1, vco[29:0], ms == 4);
            add(ADDR_PLLRST, chl ? DATA_RST_B : DATA_RST_A, vco[29:0], ERR_OK, 1'b0);
            add(chl ? ADDR_CLK1 : ADDR_CLK0, chl ? DATA_CLK1 : DATA_CLK0, vco[29:0],
                ERR_OK, 1'b1);
        endfunction

        function void check_write(t_write got);
            t_write w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected write addr=%0d data=%h", got.addr, got.data);
                return;
            end
            w = pending.pop_front();
            if (got.addr !== w.addr || got.data !== w.data || got.vco !== w.vco ||
                got.err !== w.err || got.last !== w.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected addr=%0d data=%h vco=%0d err=%0d last=%0d, got addr=%0d data=%h vco=%0d err=%0d last=%0d",
                             w.addr, w.data, w.vco, w.err, w.last,
                             got.addr, got.data, got.vco, got.err, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_channel = 1'b0;
    logic [27:0] i_target_freq = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_reg_address;
    logic [7:0]  o_reg_data;
    logic [29:0] o_vco_freq;
    logic [1:0]  o_error_code;
    logic        o_last_write;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [29:0] i_cfg_data = '0;

    write_scoreboard sb = new();
    bit idling = 1'b1;
    int cycles = 0;

    pll_divider_register_calc uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_write got;
        if (i_rst_n && o_valid && i_ready) begin
            got.addr = o_reg_address;
            got.data = o_reg_data;
            got.vco = o_vco_freq;
            got.err = o_error_code;
            got.last = o_last_write;
            sb.check_write(got);
        end
    end

    // The receiver stalls in short random bursts while idling is enabled.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idling && $urandom_range(0, 5) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            i_ready = 1'b1;
        end
    end

    task automatic send_request(logic chl, logic [27:0] freq);
        if (idling && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        i_valid = 1'b1;
        i_channel = chl;
        i_target_freq = freq;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(chl, freq);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic write_register(logic [1:0] idx, logic [29:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_XTAL) sb.xtal = value[25:0];
        else if (idx == CFG_VCO_CEIL) sb.vco_ceil = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    // Mostly frequencies that land in the legal divider range, some noise.
    task automatic random_requests(int count);
        logic [27:0] freq;
        int lo, hi;
        for (int n = 0; n < count; n++) begin
            lo = sb.vco_ceil / 127 + 1;
            hi = sb.vco_ceil / 4;
            case ($urandom_range(0, 9))
                0: freq = 28'($urandom);
                1: freq = 28'($urandom_range(0, 1000));
                default: freq = 28'($urandom_range(lo, hi));
            endcase
            send_request(1'($urandom), freq);
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_request(1'b0, 28'd0);
        send_request(1'b1, 28'd1);
        send_request(1'b0, 28'hFFFFFFF);
        send_request(1'b1, 28'd225000000);
        send_request(1'b0, 28'd225000001);
        send_request(1'b1, 28'd7142858);
        send_request(1'b0, 28'd7086614);
        send_request(1'b1, 28'd7000000);
        send_request(1'b0, 28'd12500000);
        send_request(1'b1, 28'd100000000);
        send_request(1'b0, 28'd10000000);
        send_request(1'b1, 28'd14318180);
        random_requests(25);
        drain();

        write_register(CFG_XTAL, 30'd10000000);
        write_register(CFG_VCO_CEIL, 30'd600000000);
        send_request(1'b0, 28'd150000000);
        send_request(1'b1, 28'd4724410);
        random_requests(25);
        drain();

        write_register(CFG_XTAL, 30'd40000000);
        write_register(CFG_VCO_CEIL, 30'd900000000);
        random_requests(25);
        drain();

        write_register(CFG_XTAL, 30'($urandom_range(10000000, 40000000)));
        write_register(CFG_VCO_CEIL, 30'($urandom_range(600000000, 900000000)));
        idling = 1'b0;
        random_requests(25);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
